[sv/cartridge_bank_mapper_with_irq_macros.svh]
// Assertion macros shared by the cartridge bank mapper RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_IRQ_MACROS_SVH

// Checked only while out of reset.
`define CBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define CBM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

[sv/cbm_pkg.sv]
// Shared types, codes and constants for the cartridge bank mapper.
// No dependencies.
package cbm_pkg;

    // Operation codes of an input transaction.
    localparam logic [2:0] OP_CPU_WR = 3'd0;
    localparam logic [2:0] OP_CPU_RD = 3'd1;
    localparam logic [2:0] OP_PPU_RD = 3'd2;
    localparam logic [2:0] OP_PPU_WR = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_IRQ_ACK = 3'd5;

    // Audio port strobe codes.
    localparam logic [2:0] STB_NONE    = 3'd0;
    localparam logic [2:0] STB_DATA_WR = 3'd1;
    localparam logic [2:0] STB_ADDR_WR = 3'd2;
    localparam logic [2:0] STB_EN_WR   = 3'd3;
    localparam logic [2:0] STB_DATA_RD = 3'd4;

    // Mirroring codes.
    localparam logic [2:0] MIR_VERTICAL   = 3'd0;
    localparam logic [2:0] MIR_HORIZONTAL = 3'd1;
    localparam logic [2:0] MIR_ONE_LOW    = 3'd2;
    localparam logic [2:0] MIR_ONE_HIGH   = 3'd3;
    localparam logic [2:0] MIR_OTHER      = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [1:0] CFG_ROM_NT    = 2'd2;

    localparam int CFG_W      = 6;
    localparam int MOD_DVD_W  = 8;
    localparam int MOD_DIV_W  = 9;
    localparam int MOD_CNT_W  = $clog2(MOD_DVD_W);
    localparam int NUM_PRG    = 3;
    localparam int NUM_CHR    = 12;

    localparam logic [14:0] IRQ_SAT = 15'h7FFF;
    localparam logic [7:0]  CIRAM_BANK = 8'hE0;

    localparam logic [5:0] PRG_BANK_RST [NUM_PRG] = '{6'd0, 6'd1, 6'd2};
    localparam logic [7:0] CHR_BANK_RST [NUM_CHR] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
        8'hE0, 8'hE1, 8'hE0, 8'hE1};

    typedef struct packed {
        logic busy;
        logic done;
    } mod_status_t;

    // Mirroring from the four nametable banks; unchanged unless all map to CIRAM.
    function automatic logic [2:0] mirror_calc(input logic [7:0] b8, input logic [7:0] b9,
                                               input logic [7:0] b10, input logic [7:0] b11,
                                               input logic [2:0] cur);
        logic [3:0] p;
        logic [2:0] m;
        p = {b8[0], b9[0], b10[0], b11[0]};
        case (p)
            4'b0101: m = MIR_VERTICAL;
            4'b0011: m = MIR_HORIZONTAL;
            4'b0000: m = MIR_ONE_LOW;
            4'b1111: m = MIR_ONE_HIGH;
            default: m = MIR_OTHER;
        endcase
        if (b8 < CIRAM_BANK || b9 < CIRAM_BANK || b10 < CIRAM_BANK || b11 < CIRAM_BANK) begin
            m = cur;
        end
        return m;
    endfunction

endpackage

[sv/cartridge_bank_mapper_with_irq.sv]
// Top level of the cartridge bank mapper: bank registers, IRQ counter, sequencer.
// Depends on cbm_pkg, cbm_mod_unit and the assertion macro header.
//
//  Channel   Direction  Handshake        Payload
//  s_        in         s_valid/s_ready  operation, bus_address, write_data
//  m_        out        m_valid/m_ready  handled, mapped_address, write_blocked,
//                                        irq_line, mirroring, sound_strobe
//  cfg_      in         cfg_wen          cfg_index, cfg_wdata
//
// Most transactions go from idle to the done state and back to idle.
// Program bank writes and PPU accesses that hit character ROM (nonzero character count) also
// pass through the calc state, where the bank remainder runs through the serial remainder unit, one bit per clock.
// One transaction is in flight at a time; s_ready is high only when idle.
// A result held by m_ready low stalls the sequencer before it returns to idle.
// Reset is synchronous; no clearing pass follows.
`include "cartridge_bank_mapper_with_irq_macros.svh"

module cartridge_bank_mapper_with_irq
    import cbm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_operation,
    input  logic [15:0]       s_bus_address,
    input  logic [7:0]        s_write_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_handled,
    output logic [20:0]       m_mapped_address,
    output logic              m_write_blocked,
    output logic              m_irq_line,
    output logic [2:0]        m_mirroring,
    output logic [2:0]        m_sound_strobe
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;

    logic [CFG_W-1:0] cfg_prg_reg, cfg_chr_reg;
    logic             cfg_rom_nt_reg;

    logic [5:0]  prg_bank_reg [NUM_PRG];
    logic [5:0]  prg_bank_next [NUM_PRG];
    logic [7:0]  chr_bank_reg [NUM_CHR];
    logic [7:0]  chr_bank_next [NUM_CHR];
    logic [1:0]  pat_dis_reg, pat_dis_next;
    logic [14:0] irq_count_reg, irq_count_next;
    logic        irq_en_reg, irq_en_next;
    logic        irq_pend_reg, irq_pend_next;
    logic [2:0]  mirror_reg, mirror_next;

    logic        res_handled_reg, res_handled_next;
    logic [20:0] res_mapped_reg, res_mapped_next;
    logic        res_blocked_reg, res_blocked_next;
    logic [2:0]  res_strobe_reg, res_strobe_next;
    logic        fin_prg_reg, fin_prg_next;
    logic [1:0]  fin_slot_reg, fin_slot_next;
    logic [9:0]  fin_off_reg, fin_off_next;

    logic        m_valid_reg, m_valid_next;
    logic        out_handled_reg, out_handled_next;
    logic [20:0] out_mapped_reg, out_mapped_next;
    logic        out_blocked_reg, out_blocked_next;
    logic        out_irq_reg, out_irq_next;
    logic [2:0]  out_mirror_reg, out_mirror_next;
    logic [2:0]  out_strobe_reg, out_strobe_next;

    logic                 mod_start;
    logic [MOD_DVD_W-1:0] mod_dividend;
    logic [MOD_DIV_W-1:0] mod_divisor;
    mod_status_t          mod_stat;
    logic [MOD_DIV_W-1:0] mod_rem;

    logic        s_accept;
    logic [6:0]  prg_total;
    logic [8:0]  chr_total;
    logic [18:0] ciram_base;
    logic [13:0] ppu_a14, ppu_adj;
    logic        ppu_pal;
    logic [3:0]  ppu_slot, ppu_idx;
    logic        ppu_slot_ok;
    logic [7:0]  ppu_bank;
    logic        ppu_bank_hi;
    logic        ppu_nt;
    logic        ppu_ciram;
    logic [9:0]  ppu_off;
    logic [3:0]  wr_slot;
    logic [1:0]  rd_slot, rd_idx;
    logic [6:0]  rd_bank;
    logic [14:0] irq_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    assign prg_total  = (cfg_prg_reg == '0) ? 7'd2 : {cfg_prg_reg, 1'b0};
    assign chr_total  = {cfg_chr_reg, 3'b000};
    assign ciram_base = (cfg_chr_reg == '0) ? 19'h02000 : {cfg_chr_reg, 13'h0000};

    // PPU decode: 0x3000-0x3EFF folds onto 0x2000-0x2EFF by clearing bit 12.
    assign ppu_a14     = s_bus_address[13:0];
    assign ppu_adj     = (ppu_a14 >= 14'h3000 && ppu_a14 < 14'h3F00) ?
                         {ppu_a14[13], 1'b0, ppu_a14[11:0]} : ppu_a14;
    assign ppu_pal     = (ppu_a14 >= 14'h3F00);
    assign ppu_slot    = ppu_adj[13:10];
    assign ppu_slot_ok = (ppu_slot < 4'(NUM_CHR));
    assign ppu_idx     = ppu_slot_ok ? ppu_slot : 4'd0;
    assign ppu_bank    = chr_bank_reg[ppu_idx];
    assign ppu_bank_hi = (ppu_bank >= CIRAM_BANK);
    assign ppu_nt      = ppu_slot[3];
    assign ppu_off     = ppu_adj[9:0];
    assign ppu_ciram   = ppu_bank_hi && (ppu_slot[3] ||
                         (ppu_slot[2] ? !pat_dis_reg[1] : !pat_dis_reg[0]));

    assign wr_slot = s_bus_address[14:11];
    assign rd_slot = s_bus_address[14:13];
    assign rd_idx  = (rd_slot == 2'd3) ? 2'd0 : rd_slot;
    assign rd_bank = (rd_slot == 2'd3) ? prg_total - 7'd1 : {1'b0, prg_bank_reg[rd_idx]};
    assign irq_inc = irq_count_reg + 15'd1;

    cbm_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (mod_dividend),
        .divisor   (mod_divisor),
        .status    (mod_stat),
        .remainder (mod_rem)
    );

    always_comb begin
        state_next       = state_reg;
        prg_bank_next    = prg_bank_reg;
        chr_bank_next    = chr_bank_reg;
        pat_dis_next     = pat_dis_reg;
        irq_count_next   = irq_count_reg;
        irq_en_next      = irq_en_reg;
        irq_pend_next    = irq_pend_reg;
        mirror_next      = mirror_reg;
        res_handled_next = res_handled_reg;
        res_mapped_next  = res_mapped_reg;
        res_blocked_next = res_blocked_reg;
        res_strobe_next  = res_strobe_reg;
        fin_prg_next     = fin_prg_reg;
        fin_slot_next    = fin_slot_reg;
        fin_off_next     = fin_off_reg;
        m_valid_next     = m_valid_reg;
        out_handled_next = out_handled_reg;
        out_mapped_next  = out_mapped_reg;
        out_blocked_next = out_blocked_reg;
        out_irq_next     = out_irq_reg;
        out_mirror_next  = out_mirror_reg;
        out_strobe_next  = out_strobe_reg;
        mod_start        = 1'b0;
        mod_dividend     = '0;
        mod_divisor      = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_handled_next = 1'b0;
                    res_mapped_next  = '0;
                    res_blocked_next = 1'b0;
                    res_strobe_next  = STB_NONE;
                    state_next       = ST_DONE;
                    case (s_operation)
                        OP_CPU_WR: begin
                            res_handled_next = 1'b1;
                            if (s_bus_address inside {[16'h4800:16'h4FFF]}) begin
                                res_strobe_next = STB_DATA_WR;
                            end else if (s_bus_address inside {[16'h5000:16'h57FF]}) begin
                                irq_count_next = {irq_count_reg[14:8], s_write_data};
                                irq_pend_next  = 1'b0;
                            end else if (s_bus_address inside {[16'h5800:16'h5FFF]}) begin
                                irq_count_next = {s_write_data[6:0], irq_count_reg[7:0]};
                                irq_en_next    = s_write_data[7];
                                irq_pend_next  = 1'b0;
                            end else if (s_bus_address inside {[16'h8000:16'hDFFF]}) begin
                                chr_bank_next[wr_slot] = s_write_data;
                                if (wr_slot[3]) begin
                                    mirror_next = mirror_calc(chr_bank_next[8],
                                        chr_bank_next[9], chr_bank_next[10],
                                        chr_bank_next[11], mirror_reg);
                                end
                            end else if (s_bus_address inside {[16'hE000:16'hF7FF]}) begin
                                // Program bank select goes through the remainder unit.
                                mod_start     = 1'b1;
                                mod_dividend  = {2'b00, s_write_data[5:0]};
                                mod_divisor   = {2'b00, prg_total};
                                fin_prg_next  = 1'b1;
                                fin_slot_next = s_bus_address[12:11];
                                state_next    = ST_CALC;
                                if (s_bus_address inside {[16'hE000:16'hE7FF]}) begin
                                    res_strobe_next = STB_EN_WR;
                                end
                                if (s_bus_address inside {[16'hE800:16'hEFFF]}) begin
                                    pat_dis_next = s_write_data[7:6];
                                end
                            end else if (s_bus_address >= 16'hF800) begin
                                res_strobe_next = STB_ADDR_WR;
                            end else begin
                                res_handled_next = 1'b0;
                            end
                        end
                        OP_CPU_RD: begin
                            if (s_bus_address inside {[16'h4800:16'h4FFF]}) begin
                                res_handled_next = 1'b1;
                                res_strobe_next  = STB_DATA_RD;
                            end else if (s_bus_address[15]) begin
                                res_handled_next = 1'b1;
                                res_mapped_next  = {1'b0, rd_bank, s_bus_address[12:0]};
                            end
                        end
                        OP_PPU_RD, OP_PPU_WR: begin
                            if (!ppu_pal && ppu_slot_ok &&
                                !(ppu_nt && (ppu_bank_hi || !cfg_rom_nt_reg))) begin
                                res_handled_next = 1'b1;
                                if (ppu_ciram) begin
                                    res_mapped_next = {2'b00, ciram_base} +
                                                      {10'd0, ppu_bank[0], ppu_off};
                                end else if (cfg_chr_reg != '0) begin
                                    mod_start        = 1'b1;
                                    mod_dividend     = ppu_bank;
                                    mod_divisor      = chr_total;
                                    fin_prg_next     = 1'b0;
                                    fin_off_next     = ppu_off;
                                    res_blocked_next = (s_operation == OP_PPU_WR);
                                    state_next       = ST_CALC;
                                end else begin
                                    res_mapped_next = {8'd0, ppu_bank[2:0], ppu_off};
                                end
                            end
                        end
                        OP_TICK: begin
                            if (irq_en_reg && !irq_pend_reg && irq_count_reg != IRQ_SAT) begin
                                irq_count_next = irq_inc;
                                if (irq_inc == IRQ_SAT) begin
                                    irq_pend_next = 1'b1;
                                end
                            end
                        end
                        OP_IRQ_ACK: begin
                            irq_pend_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CALC: begin
                if (mod_stat.done) begin
                    if (fin_prg_reg) begin
                        prg_bank_next[fin_slot_reg] = mod_rem[5:0];
                    end else begin
                        res_mapped_next = {2'b00, mod_rem, fin_off_reg};
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    out_handled_next = res_handled_reg;
                    out_mapped_next  = res_mapped_reg;
                    out_blocked_next = res_blocked_reg;
                    out_irq_next     = irq_pend_reg;
                    out_mirror_next  = mirror_reg;
                    out_strobe_next  = res_strobe_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            cfg_prg_reg    <= CFG_W'(16);
            cfg_chr_reg    <= CFG_W'(16);
            cfg_rom_nt_reg <= 1'b0;
            prg_bank_reg   <= PRG_BANK_RST;
            chr_bank_reg   <= CHR_BANK_RST;
            pat_dis_reg    <= '0;
            irq_count_reg  <= '0;
            irq_en_reg     <= 1'b0;
            irq_pend_reg   <= 1'b0;
            mirror_reg     <= MIR_VERTICAL;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            prg_bank_reg  <= prg_bank_next;
            chr_bank_reg  <= chr_bank_next;
            pat_dis_reg   <= pat_dis_next;
            irq_count_reg <= irq_count_next;
            irq_en_reg    <= irq_en_next;
            irq_pend_reg  <= irq_pend_next;
            mirror_reg    <= mirror_next;
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_PRG_COUNT: cfg_prg_reg    <= cfg_wdata;
                    CFG_CHR_COUNT: cfg_chr_reg    <= cfg_wdata;
                    CFG_ROM_NT:    cfg_rom_nt_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
        res_handled_reg <= res_handled_next;
        res_mapped_reg  <= res_mapped_next;
        res_blocked_reg <= res_blocked_next;
        res_strobe_reg  <= res_strobe_next;
        fin_prg_reg     <= fin_prg_next;
        fin_slot_reg    <= fin_slot_next;
        fin_off_reg     <= fin_off_next;
        out_handled_reg <= out_handled_next;
        out_mapped_reg  <= out_mapped_next;
        out_blocked_reg <= out_blocked_next;
        out_irq_reg     <= out_irq_next;
        out_mirror_reg  <= out_mirror_next;
        out_strobe_reg  <= out_strobe_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_handled        = out_handled_reg;
    assign m_mapped_address = out_mapped_reg;
    assign m_write_blocked  = out_blocked_reg;
    assign m_irq_line       = out_irq_reg;
    assign m_mirroring      = out_mirror_reg;
    assign m_sound_strobe   = out_strobe_reg;

    `CBM_ASSERT(a_pend_at_sat, $rose(irq_pend_reg) |-> irq_count_reg == IRQ_SAT,
        "IRQ pending below saturation")
    `CBM_ASSERT(a_calc_has_unit, state_reg == ST_CALC |-> mod_stat.busy || mod_stat.done,
        "sequencer waits on an idle remainder unit")
    `CBM_ASSERT_RST(a_reset_idle, !aresetn |=> !m_valid_reg && state_reg == ST_IDLE,
        "reset did not clear the sequencer")

endmodule

[sv/cbm_mod_unit.sv]
// Bit-serial remainder unit: one restoring step per clock, MSB of the dividend first.
// Depends on cbm_pkg and the assertion macro header.
`include "cartridge_bank_mapper_with_irq_macros.svh"

module cbm_mod_unit
    import cbm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [MOD_DVD_W-1:0] dividend,
    input  logic [MOD_DIV_W-1:0] divisor,
    output mod_status_t          status,
    output logic [MOD_DIV_W-1:0] remainder
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [MOD_DVD_W-1:0] dvd_reg, dvd_next;
    logic [MOD_DIV_W-1:0] div_reg, div_next;
    logic [MOD_DIV_W-1:0] rem_reg, rem_next;
    logic [MOD_DIV_W:0]   trial;
    logic [MOD_DIV_W:0]   reduced;

    assign trial   = {rem_reg, dvd_reg[MOD_DVD_W-1]};
    assign reduced = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = reduced[MOD_DIV_W-1:0];
            dvd_next = {dvd_reg[MOD_DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

    `CBM_ASSERT(a_rem_below_div, done_reg |-> (rem_reg < div_reg), "remainder not below divisor")
    `CBM_ASSERT(a_done_after_run, done_reg |-> $past(busy_reg), "done without a preceding run")
    `CBM_ASSERT(a_no_restart, start |-> !busy_reg, "remainder unit restarted while busy")

endmodule
